// ===== design/md4_pkg.sv =====
// Shared constants, types and step functions of the MD4 digest core.
// Used by md4_front, md4_queue, md4_back and md4_message_digest_core; no dependencies.
package md4_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [31:0] K_ROUND2 = 32'h5a827999;
	localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	// Word slot of the low half of the bit count inside the last block.
	localparam logic [3:0] LEN_LO_IDX = 4'd14;
	localparam logic [3:0] LAST_WORD_IDX = 4'd15;
	localparam logic [5:0] LAST_STEP = 6'd47;
	localparam logic [1:0] LAST_OUT_IDX = 2'd3;
	localparam logic [1:0] LAST_LANE = 2'd3;

	localparam int QUEUE_DEPTH_DEF = 16;

	typedef logic [1:0] round_t;
	localparam round_t ROUND_1 = 2'd0;
	localparam round_t ROUND_2 = 2'd1;
	localparam round_t ROUND_3 = 2'd2;

	// One message word handed from the front to the back.
	typedef struct packed {
		logic [31:0] word;
		logic        msg_end;
	} word_cmd_t;

	// Message word used by a compression step.
	function automatic logic [3:0] word_index(input logic [5:0] step);
		logic [3:0] idx;
		case (step[5:4])
			ROUND_1: idx = step[3:0];
			ROUND_2: idx = {step[1:0], step[3:2]};
			ROUND_3: idx = {step[0], step[1], step[2], step[3]};
			default: idx = step[3:0];
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] step);
		logic [4:0] amt;
		case ({step[5:4], step[1:0]})
			4'b00_00: amt = 5'd3;
			4'b00_01: amt = 5'd7;
			4'b00_10: amt = 5'd11;
			4'b00_11: amt = 5'd19;
			4'b01_00: amt = 5'd3;
			4'b01_01: amt = 5'd5;
			4'b01_10: amt = 5'd9;
			4'b01_11: amt = 5'd13;
			4'b10_00: amt = 5'd3;
			4'b10_01: amt = 5'd9;
			4'b10_10: amt = 5'd11;
			4'b10_11: amt = 5'd15;
			default:  amt = 5'd3;
		endcase
		return amt;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] t;
		t = {v, v} << n;
		return t[63:32];
	endfunction

	// Round function plus round constant.
	function automatic logic [31:0] round_mix(input logic [1:0] round,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (round)
			ROUND_1: f = (b & c) | (~b & d);
			ROUND_2: f = ((b & c) | (b & d) | (c & d)) + K_ROUND2;
			ROUND_3: f = (b ^ c ^ d) + K_ROUND3;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

// ===== design/md4_in_if.sv =====
// Byte input channel of the MD4 digest core: valid/ready handshake and payload.
// No dependencies.
interface md4_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output has_byte, output last_byte,
		input ready);
	modport sink(input valid, input data_byte, input has_byte, input last_byte,
		output ready);
endinterface

// ===== design/md4_out_if.sv =====
// Digest output channel of the MD4 digest core: valid/ready handshake and payload.
// No dependencies.
interface md4_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        last_word;

	modport source(output valid, output digest_word, output last_word, input ready);
	modport sink(input valid, input digest_word, input last_word, output ready);
endinterface

// ===== design/md4_front.sv =====
// Front end: takes message bytes, packs them into little-endian words, counts bits
// and generates the padding and length words. Depends on md4_pkg and md4_in_if.
module md4_front (
	input  logic                   clk,
	input  logic                   arst_n,
	md4_in_if.sink                 msg,
	output logic                   push_valid,
	output md4_pkg::word_cmd_t     push_cmd,
	input  logic                   push_ready
);

	typedef enum logic [3:0] {
		F_BYTES = 4'b0001,
		F_PAD   = 4'b0010,
		F_ZERO  = 4'b0100,
		F_LEN   = 4'b1000
	} front_state_t;

	front_state_t state_q;
	logic [63:0]  bit_cnt_q;
	logic [31:0]  acc_q;
	logic [3:0]   widx_q;
	logic [1:0]   lane;
	logic [31:0]  pad_word;
	logic         msg_xfer;

	assign lane = bit_cnt_q[4:3];
	assign msg.ready = (state_q == F_BYTES) && push_ready;
	assign msg_xfer = msg.valid && msg.ready;

	// Bytes below the fill point are kept, the pad byte follows, the rest is zero.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (2'(k) < lane) begin
				pad_word[k*8 +: 8] = acc_q[k*8 +: 8];
			end else if (2'(k) == lane) begin
				pad_word[k*8 +: 8] = md4_pkg::PAD_BYTE;
			end else begin
				pad_word[k*8 +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		push_valid = 1'b0;
		push_cmd.word = '0;
		push_cmd.msg_end = 1'b0;
		case (state_q)
			F_BYTES: begin
				push_valid = msg.valid && msg.has_byte && (lane == md4_pkg::LAST_LANE);
				push_cmd.word = {msg.data_byte, acc_q[23:0]};
			end
			F_PAD: begin
				push_valid = 1'b1;
				push_cmd.word = pad_word;
			end
			F_ZERO: begin
				push_valid = 1'b1;
				push_cmd.word = (widx_q == md4_pkg::LEN_LO_IDX) ? bit_cnt_q[31:0] : 32'h0;
			end
			F_LEN: begin
				push_valid = 1'b1;
				push_cmd.word = bit_cnt_q[63:32];
				push_cmd.msg_end = 1'b1;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_BYTES;
			bit_cnt_q <= '0;
			widx_q <= '0;
		end else begin
			case (state_q)
				F_BYTES: begin
					if (msg_xfer) begin
						if (msg.has_byte) begin
							bit_cnt_q <= bit_cnt_q + 64'd8;
						end
						if (msg.last_byte) begin
							state_q <= F_PAD;
						end
					end
				end
				F_PAD: begin
					if (push_ready) begin
						widx_q <= bit_cnt_q[8:5] + 4'd1;
						state_q <= F_ZERO;
					end
				end
				F_ZERO: begin
					if (push_ready) begin
						if (widx_q == md4_pkg::LEN_LO_IDX) begin
							state_q <= F_LEN;
						end else begin
							widx_q <= widx_q + 4'd1;
						end
					end
				end
				F_LEN: begin
					if (push_ready) begin
						bit_cnt_q <= '0;
						state_q <= F_BYTES;
					end
				end
				default: begin
					state_q <= F_BYTES;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (msg_xfer && msg.has_byte) begin
			acc_q[lane*8 +: 8] <= msg.data_byte;
		end
	end

endmodule

// ===== design/md4_queue.sv =====
// Word queue between the front and the back of the MD4 digest core.
// Depends on md4_pkg.
module md4_queue #(
	parameter int DEPTH = md4_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  md4_pkg::word_cmd_t push_cmd,
	output logic               push_ready,
	output logic               pop_valid,
	output md4_pkg::word_cmd_t pop_cmd,
	input  logic               pop_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	md4_pkg::word_cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== design/md4_back.sv =====
// Back end: loads 16-word blocks, runs the 48 MD4 steps one per cycle, updates the
// chaining words and sends the digest. Depends on md4_pkg and md4_out_if.
module md4_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  md4_pkg::word_cmd_t pop_cmd,
	output logic               pop_ready,
	md4_out_if.source          digest
);

	typedef enum logic [3:0] {
		B_LOAD = 4'b0001,
		B_RUN  = 4'b0010,
		B_ADD  = 4'b0100,
		B_OUT  = 4'b1000
	} back_state_t;

	back_state_t state_q;
	logic [31:0] msg_q [16];
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [3:0]  widx_q;
	logic [5:0]  step_q;
	logic [1:0]  oidx_q;
	logic        end_q;
	logic        pop_xfer;
	logic        out_xfer;
	logic [31:0] step_sum;
	logic [31:0] step_new;

	assign pop_ready = (state_q == B_LOAD);
	assign pop_xfer = pop_valid && pop_ready;

	assign digest.valid = (state_q == B_OUT);
	assign digest.digest_word = chain_q[oidx_q];
	assign digest.last_word = (oidx_q == md4_pkg::LAST_OUT_IDX);
	assign out_xfer = digest.valid && digest.ready;

	// The working words rotate each step so the updated word is always a_q.
	assign step_sum = a_q + md4_pkg::round_mix(step_q[5:4], b_q, c_q, d_q)
		+ msg_q[md4_pkg::word_index(step_q)];
	assign step_new = md4_pkg::rotl32(step_sum, md4_pkg::rot_amount(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
			widx_q <= '0;
			step_q <= '0;
			oidx_q <= '0;
			end_q <= 1'b0;
			chain_q[0] <= md4_pkg::INIT_A;
			chain_q[1] <= md4_pkg::INIT_B;
			chain_q[2] <= md4_pkg::INIT_C;
			chain_q[3] <= md4_pkg::INIT_D;
		end else begin
			case (state_q)
				B_LOAD: begin
					if (pop_xfer) begin
						widx_q <= widx_q + 4'd1;
						if (widx_q == md4_pkg::LAST_WORD_IDX) begin
							end_q <= pop_cmd.msg_end;
							step_q <= '0;
							state_q <= B_RUN;
						end
					end
				end
				B_RUN: begin
					step_q <= step_q + 6'd1;
					if (step_q == md4_pkg::LAST_STEP) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					oidx_q <= '0;
					state_q <= end_q ? B_OUT : B_LOAD;
				end
				B_OUT: begin
					if (out_xfer) begin
						oidx_q <= oidx_q + 2'd1;
						if (oidx_q == md4_pkg::LAST_OUT_IDX) begin
							chain_q[0] <= md4_pkg::INIT_A;
							chain_q[1] <= md4_pkg::INIT_B;
							chain_q[2] <= md4_pkg::INIT_C;
							chain_q[3] <= md4_pkg::INIT_D;
							state_q <= B_LOAD;
						end
					end
				end
				default: begin
					state_q <= B_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_xfer) begin
			msg_q[widx_q] <= pop_cmd.word;
		end
		if (pop_xfer && (widx_q == md4_pkg::LAST_WORD_IDX)) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == B_RUN) begin
			a_q <= d_q;
			b_q <= step_new;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

endmodule

// ===== design/md4_message_digest_core.sv =====
// MD4 message digest core: ties the byte front end, the word queue and the
// compression back end together. Depends on md4_pkg, md4_in_if, md4_out_if and submodules.
//
// Bytes enter on the msg channel, at most one per transfer, and a transfer with
// last_byte set closes the message; the digest then leaves on the digest channel as
// four 32-bit words A, B, C, D (little-endian bytes), the last one flagged, and the
// core starts over on a fresh message. The front end takes one byte per cycle while
// not padding and the queue has room, and hands packed words to a QUEUE_DEPTH-word queue.
// The back end is the limit: it loads 16 words (one per cycle once they are queued),
// runs the 48 MD4 steps one per cycle on a single step unit and then does the chaining
// add; the queue soaks up the bytes that arrive during compression, so a long message
// streams at close to one byte per cycle. Closing a message sends the pad, zero and
// length words, taking no bytes meanwhile, then one or two block compressions and four
// digest transfers, during which no new bytes are taken once the queue is full.
module md4_message_digest_core #(
	parameter int QUEUE_DEPTH = md4_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	md4_in_if.sink    msg,
	md4_out_if.source digest
);

	logic               push_valid;
	logic               push_ready;
	md4_pkg::word_cmd_t push_cmd;
	logic               pop_valid;
	logic               pop_ready;
	md4_pkg::word_cmd_t pop_cmd;

	md4_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	md4_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop_ready  (pop_ready)
	);

	md4_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd),
		.pop_ready (pop_ready),
		.digest    (digest)
	);

endmodule

// ===== verif/md4_digest_checker.sv =====
`timescale 1ns / 1ps
// Digest checker for the MD4 digest core. It predicts the digest of every message seen on the byte
// channel and compares each digest channel transfer with it. Depends on md4_pkg, md4_in_if, md4_out_if.
module md4_digest_checker (
	input  logic clk,
	input  logic arst_n,
	md4_in_if    msg,
	md4_out_if   digest,
	output int   mismatches,
	output int   words_due
);

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [31:0] MAJ_ADD = 32'h5a827999;
	localparam logic [31:0] XOR_ADD = 32'h6ed9eba1;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam int BLOCK_LEN = 64;
	localparam int LEN_SLOT = 56;
	localparam int WORDS_PER_DIGEST = 4;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_beat_t;

	int word_sel [48] = '{
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
		0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
		0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
	int rot_by [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

	logic [31:0]  chain [4];
	logic [7:0]   block_bytes [64];
	logic [63:0]  msg_bits;
	digest_beat_t digest_due [$];
	digest_beat_t beat;

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic restart_chain();
		chain[0] = IV_A;
		chain[1] = IV_B;
		chain[2] = IV_C;
		chain[3] = IV_D;
		msg_bits = '0;
	endtask

	task automatic compress_block();
		logic [31:0]      m [16];
		logic [31:0]      r [4];
		logic [31:0]      b, c, d, f;
		md4_pkg::round_t  rnd;
		int               i, ia;
		for (i = 0; i < 16; i++)
			m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
		for (i = 0; i < 4; i++)
			r[i] = chain[i];
		// Each step rewrites one register; the target walks backwards A, D, C, B.
		for (i = 0; i < 48; i++) begin
			rnd = md4_pkg::round_t'(i / 16);
			ia = (4 - (i % 4)) % 4;
			b = r[(ia + 1) % 4];
			c = r[(ia + 2) % 4];
			d = r[(ia + 3) % 4];
			case (rnd)
				md4_pkg::ROUND_1: f = (b & c) | (~b & d);
				md4_pkg::ROUND_2: f = ((b & c) | (b & d) | (c & d)) + MAJ_ADD;
				default: f = (b ^ c ^ d) + XOR_ADD;
			endcase
			r[ia] = rol(r[ia] + f + m[word_sel[i]], rot_by[int'(rnd) * 4 + i % 4]);
		end
		for (i = 0; i < 4; i++)
			chain[i] = chain[i] + r[i];
	endtask

	task automatic absorb_item(input logic [7:0] data, input logic has, input logic last);
		int fill, j;
		if (has) begin
			fill = int'(msg_bits[8:3]);
			block_bytes[fill] = data;
			msg_bits = msg_bits + 64'd8;
			if (fill == BLOCK_LEN - 1)
				compress_block();
		end
		if (last) begin
			fill = int'(msg_bits[8:3]);
			block_bytes[fill] = PAD_MARK;
			fill++;
			// No room left for the length field, so padding spills into one more block.
			if (fill > LEN_SLOT) begin
				while (fill < BLOCK_LEN) begin
					block_bytes[fill] = 8'h00;
					fill++;
				end
				compress_block();
				fill = 0;
			end
			while (fill < LEN_SLOT) begin
				block_bytes[fill] = 8'h00;
				fill++;
			end
			for (j = 0; j < 8; j++)
				block_bytes[LEN_SLOT + j] = msg_bits[8*j +: 8];
			compress_block();
			for (j = 0; j < WORDS_PER_DIGEST; j++)
				digest_due.push_back('{word: chain[j], last: (j == WORDS_PER_DIGEST - 1)});
			restart_chain();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_chain();
			digest_due.delete();
			mismatches <= 0;
			words_due <= 0;
		end else begin
			if (msg.valid && msg.ready)
				absorb_item(msg.data_byte, msg.has_byte, msg.last_byte);
			if (digest.valid && digest.ready) begin
				if (digest_due.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: digest transfer with nothing expected: word %h last %b",
							$realtime, digest.digest_word, digest.last_word);
					mismatches <= mismatches + 1;
				end else begin
					beat = digest_due.pop_front();
					if (beat.word !== digest.digest_word || beat.last !== digest.last_word) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: digest mismatch: expected word %h last %b, got word %h last %b",
								$realtime, beat.word, beat.last, digest.digest_word, digest.last_word);
						mismatches <= mismatches + 1;
					end
				end
			end
			words_due <= digest_due.size();
		end
	end

endmodule

// ===== verif/md4_message_digest_core_test.sv =====
`timescale 1ns / 1ps
// Top of the MD4 digest core testbench: clock, reset, byte stimulus, digest back-pressure and verdict.
// Depends on md4_message_digest_core, md4_in_if, md4_out_if and md4_digest_checker.
module md4_message_digest_core_test;

	typedef enum int {RX_OPEN, RX_SPARSE, RX_DENSE, RX_SHUT} rx_mode_t;

	localparam int RANDOM_ITEMS = 200;
	localparam int RANDOM_MESSAGES = 6;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 300;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   words_due;

	int   burst_left;
	int   rand_items;
	int   messages_sent;
	bit   squeeze_now;
	int   boundary_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	md4_in_if  msg_ch ();
	md4_out_if digest_ch ();

	md4_message_digest_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	md4_digest_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg_ch),
		.digest     (digest_ch),
		.mismatches (mismatches),
		.words_due  (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Offers one item and returns once the transfer has happened. Gaps come between bursts.
	task automatic push_item(input logic [7:0] data, input logic has, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				msg_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
		end
		@(negedge clk);
		msg_ch.valid <= 1'b1;
		msg_ch.data_byte <= data;
		msg_ch.has_byte <= has;
		msg_ch.last_byte <= last;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic send_message(input int len);
		int k;
		bit joined;
		logic [7:0] b;
		// About half of the non-empty messages end on the transfer that carries their final byte.
		joined = (len > 0) && ($urandom_range(0, 1) == 1);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				rand_items++;
			end
			case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = 8'hff;
				default: b = 8'($urandom_range(0, 255));
			endcase
			push_item(b, 1'b1, joined && (k == len - 1));
			rand_items++;
		end
		if (!joined) begin
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			rand_items++;
		end
		messages_sent++;
	endtask

	initial begin
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = 8'h00;
		msg_ch.has_byte = 1'b0;
		msg_ch.last_byte = 1'b0;
		burst_left = 0;
		rand_items = 0;
		messages_sent = 0;
		squeeze_now = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_item(8'hff, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b1);
		push_item(8'hff, 1'b1, 1'b0);
		push_item(8'h5a, 1'b0, 1'b0);
		push_item(8'hff, 1'b0, 1'b1);
		push_item(8'h80, 1'b1, 1'b0);
		push_item(8'h7f, 1'b1, 1'b1);
		push_item(8'ha5, 1'b0, 1'b1);

		squeeze_now = 1'b1;
		while (rand_items < RANDOM_ITEMS || messages_sent < RANDOM_MESSAGES) begin
			if ($urandom_range(0, 3) == 0)
				send_message(boundary_len[$urandom_range(0, 9)]);
			else
				send_message($urandom_range(0, 20));
		end
		@(negedge clk);
		msg_ch.valid <= 1'b0;

		while (words_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Digest side back-pressure, with one long hold-off so that the core backs up into its input.
	initial begin
		rx_mode_t mode;
		int len;
		bit held;
		digest_ch.ready = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (squeeze_now && !held) begin
				@(negedge clk);
				digest_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end else begin
				mode = rx_mode_t'($urandom_range(0, 3));
				len = (mode == RX_SHUT) ? $urandom_range(1, 12) : $urandom_range(1, 40);
				repeat (len) begin
					@(negedge clk);
					case (mode)
						RX_OPEN:   digest_ch.ready <= 1'b1;
						RX_SPARSE: digest_ch.ready <= ($urandom_range(0, 3) == 0);
						RX_DENSE:  digest_ch.ready <= ($urandom_range(0, 3) != 0);
						default:   digest_ch.ready <= 1'b0;
					endcase
				end
			end
		end
	end

endmodule

// ===== md4_message_digest_core.f =====
design/md4_pkg.sv
design/md4_in_if.sv
design/md4_out_if.sv
design/md4_front.sv
design/md4_queue.sv
design/md4_back.sv
design/md4_message_digest_core.sv
verif/md4_digest_checker.sv
verif/md4_message_digest_core_test.sv
